@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the tracker RTL
// Clocked concurrent checks on clk_i, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check gated off while rst_ni is low.
`define IKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define IKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/ikt_pkg.sv @@
// ---------------------------------------------------------------------------
// ikt_pkg
// Types and constants of the IR key press / hold event tracker.
// ---------------------------------------------------------------------------
package ikt_pkg;

  localparam int KEYS          = 32;
  localparam int TABLE_ENTRIES = 32;
  localparam int BTN_W         = $clog2(KEYS);
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int QUEUE_DEPTH   = 2;

  // per-button flag bits
  localparam int FLAG_W      = 5;
  localparam int FL_HELD     = 0;
  localparam int FL_PRESS    = 1;
  localparam int FL_LONG     = 2;
  localparam int FL_LONG_TRG = 3;
  localparam int FL_HOLD     = 4;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME       = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TIMEOUT = 8'd1;
  localparam logic [CFG_W-1:0]     HOLD_TIME_RST       = 16'd500;
  localparam logic [CFG_W-1:0]     RELEASE_TIMEOUT_RST = 16'd100;

  localparam logic [31:0] TIME_LO_MASK = 32'h0000_FFFF;

  typedef enum logic [1:0] {
    FUNC_POLL  = 2'd0,
    FUNC_FRAME = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_WRITE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_PRESS = 2'd0,
    KIND_LONG  = 2'd1,
    KIND_HOLD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] btn;
    logic [7:0] interval;
    logic       long_ok;
    logic       hold_ok;
  } key_entry_t;

  // classified request handed from front to back
  typedef struct packed {
    func_e             func;
    logic [31:0]       now_ms;
    logic              matched;
    logic [BTN_W-1:0]  btn;
    logic [1:0]        kind;
    logic              long_ok;
    logic              hold_ok;
    logic [7:0]        interval;
  } job_t;

  typedef struct packed {
    logic [CFG_W-1:0] hold_time_ms;
    logic [CFG_W-1:0] release_timeout_ms;
  } cfg_t;

endpackage

@@ rtl/ikt_front.sv @@
// ---------------------------------------------------------------------------
// ikt_front
// Accepts requests, owns the key table, scans it for frames and queues a
// classified job per request.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ikt_front import ikt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic [31:0]       now_ms_i,
  input  logic [7:0]        ir_address_i,
  input  logic [7:0]        ir_command_i,
  input  logic [BTN_W-1:0]  button_i,
  input  logic [1:0]        event_kind_i,
  input  logic [SLOT_W-1:0] table_slot_i,
  input  logic [7:0]        entry_button_i,
  input  logic              entry_long_ok_i,
  input  logic              entry_hold_ok_i,
  input  logic [7:0]        entry_interval_i,
  input  logic              entry_valid_i,
  input  logic              full_i,
  output logic              push_o,
  output job_t              job_o
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_PUSH   = 3'b100
  } state_e;

  state_e                   state_q, state_d;
  job_t                     job_q, job_d;
  logic [SLOT_W-1:0]        cmp_idx_q, cmp_idx_d;
  logic [SLOT_W-1:0]        rd_addr;
  key_entry_t               tbl_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tbl_vld_q;
  key_entry_t               rd_q;
  logic                     rd_vld_q;
  logic [7:0]               addr_q, cmd_q;
  logic                     accept, wr_en, hit, last;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign wr_en      = accept && (func_i == FUNC_WRITE);
  // scan address runs one entry ahead of the compare
  assign rd_addr    = (state_q == S_SEARCH) ? SLOT_W'(cmp_idx_q + 1'b1) : '0;
  assign hit        = rd_vld_q && (rd_q.addr == addr_q) && (rd_q.cmd == cmd_q);
  assign last       = (cmp_idx_q == SLOT_W'(TABLE_ENTRIES - 1));
  assign job_o      = job_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[table_slot_i] <= '{addr:     ir_address_i,
                                 cmd:      ir_command_i,
                                 btn:      entry_button_i,
                                 interval: entry_interval_i,
                                 long_ok:  entry_long_ok_i,
                                 hold_ok:  entry_hold_ok_i};
    end
    rd_q <= tbl_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= ir_address_i;
      cmd_q  <= ir_command_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_vld_q[table_slot_i] <= entry_valid_i;
      end
      rd_vld_q <= tbl_vld_q[rd_addr];
    end
  end

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    cmp_idx_d = cmp_idx_q;
    push_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          job_d.func     = func_e'(func_i);
          job_d.now_ms   = now_ms_i;
          job_d.matched  = 1'b0;
          job_d.btn      = button_i;
          job_d.kind     = event_kind_i;
          job_d.long_ok  = 1'b0;
          job_d.hold_ok  = 1'b0;
          job_d.interval = '0;
          cmp_idx_d      = '0;
          state_d        = (func_i == FUNC_FRAME) ? S_SEARCH : S_PUSH;
        end
      end
      S_SEARCH: begin
        if (hit || last) begin
          // first match wins; an out-of-range button still ends the scan
          job_d.matched  = hit && ({1'b0, rd_q.btn} < 9'(KEYS));
          job_d.btn      = rd_q.btn[BTN_W-1:0];
          job_d.long_ok  = rd_q.long_ok;
          job_d.hold_ok  = rd_q.hold_ok;
          job_d.interval = rd_q.interval;
          state_d        = S_PUSH;
        end else begin
          cmp_idx_d = SLOT_W'(cmp_idx_q + 1'b1);
        end
      end
      S_PUSH: begin
        push_o = !full_i;
        if (!full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      cmp_idx_q <= cmp_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  `IKT_ASSERT(a_frame_starts_scan,
    (accept && (func_i == FUNC_FRAME)) |=> (state_q == S_SEARCH && cmp_idx_q == '0),
    "frame request did not start the table scan at entry zero")
  `IKT_ASSERT(a_scan_steps,
    (state_q == S_SEARCH && !hit && !last) |=>
      (state_q == S_SEARCH && cmp_idx_q == SLOT_W'($past(cmp_idx_q) + 1'b1)),
    "table scan skipped or repeated an entry")

endmodule

@@ rtl/ikt_queue.sv @@
// ---------------------------------------------------------------------------
// ikt_queue
// Short job FIFO between the front and the back.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ikt_queue import ikt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= CNT_W'(count_q + 1'b1);
      end else if (pop_i && !push_i) begin
        count_q <= CNT_W'(count_q - 1'b1);
      end
    end
  end

  `IKT_ASSERT(a_no_push_full, push_i |-> !full_o, "push into a full job queue")
  `IKT_ASSERT_ALWAYS(a_no_pop_empty, pop_i |-> valid_o, "pop from an empty job queue")
  `IKT_ASSERT(a_count_up,
    (push_i && !pop_i) |=> (count_q == CNT_W'($past(count_q) + 1'b1)),
    "queue fill count lost a push")

endmodule

@@ rtl/ikt_back.sv @@
// ---------------------------------------------------------------------------
// ikt_back
// Executes queued jobs on the button flags and timers, one per cycle while
// the output register is empty or being read, and holds each result there.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ikt_back import ikt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic event_seen_o,
  output logic frame_matched_o
);

  logic [FLAG_W-1:0] flags_q [KEYS];
  logic [15:0]       first_q, last_hold_q;
  logic [31:0]       last_frame_q;
  logic              out_valid_q, seen_q, matched_q;

  logic [15:0]       t16, first_eff, since_first, since_hold;
  logic [FLAG_W-1:0] f_cur, f_new, qmask;
  logic              hold_upd, timeout, qvalid;

  assign pop_o           = job_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o     = out_valid_q;
  assign event_seen_o    = seen_q;
  assign frame_matched_o = matched_q;

  assign t16         = 16'(job_i.now_ms & TIME_LO_MASK);
  assign f_cur       = flags_q[job_i.btn];
  // zero start time means unset
  assign first_eff   = (first_q == '0) ? t16 : first_q;
  assign since_first = 16'(t16 - first_eff);
  assign since_hold  = 16'(t16 - last_hold_q);
  assign timeout     = 32'(job_i.now_ms - last_frame_q) >= {16'b0, cfg_i.release_timeout_ms};

  always_comb begin
    f_new    = f_cur;
    hold_upd = 1'b0;
    if (!f_cur[FL_HELD]) begin
      f_new[FL_HELD]  = 1'b1;
      f_new[FL_PRESS] = 1'b1;
    end
    if (since_first >= cfg_i.hold_time_ms) begin
      if (job_i.long_ok && !f_new[FL_LONG_TRG]) begin
        f_new[FL_LONG]     = 1'b1;
        f_new[FL_LONG_TRG] = 1'b1;
      end
      if (job_i.hold_ok) begin
        if ((last_hold_q == '0) || (since_hold >= {8'b0, job_i.interval})) begin
          hold_upd       = 1'b1;
          f_new[FL_HOLD] = 1'b1;
        end else begin
          f_new[FL_HOLD] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    qmask  = '0;
    qvalid = 1'b1;
    unique case (job_i.kind)
      KIND_PRESS: qmask[FL_PRESS] = 1'b1;
      KIND_LONG:  qmask[FL_LONG]  = 1'b1;
      KIND_HOLD:  qmask[FL_HOLD]  = 1'b1;
      default:    qvalid          = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEYS; i++) begin
        flags_q[i] <= '0;
      end
      first_q      <= '0;
      last_hold_q  <= '0;
      last_frame_q <= '0;
      out_valid_q  <= 1'b0;
      seen_q       <= 1'b0;
      matched_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        unique case (job_i.func)
          FUNC_POLL: begin
            if (timeout) begin
              for (int i = 0; i < KEYS; i++) begin
                flags_q[i] <= '0;
              end
              first_q     <= '0;
              last_hold_q <= '0;
            end
          end
          FUNC_FRAME: begin
            last_frame_q <= job_i.now_ms;
            if (job_i.matched) begin
              flags_q[job_i.btn] <= f_new;
              first_q            <= first_eff;
              if (hold_upd) begin
                last_hold_q <= t16;
              end
            end
          end
          FUNC_QUERY: begin
            if (qvalid) begin
              flags_q[job_i.btn] <= f_cur & ~qmask;
            end
          end
          FUNC_WRITE: ;
          default: ;
        endcase
        out_valid_q <= 1'b1;
        seen_q      <= (job_i.func == FUNC_QUERY) && qvalid && |(f_cur & qmask);
        matched_q   <= (job_i.func == FUNC_FRAME) && job_i.matched;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `IKT_ASSERT(a_pop_gives_result, pop_o |=> out_valid_q, "executed job produced no result")
  `IKT_ASSERT(a_timeout_clears,
    (pop_o && job_i.func == FUNC_POLL && timeout) |=> (first_q == '0 && last_hold_q == '0),
    "release timeout left hold timers set")
  `IKT_ASSERT(a_query_clears,
    (pop_o && job_i.func == FUNC_QUERY && qvalid) |=>
      ((flags_q[$past(job_i.btn)] & $past(qmask)) == '0),
    "query did not clear the flag it read")

endmodule

@@ rtl/ir_key_press_hold_event_tracker.sv @@
// ---------------------------------------------------------------------------
// ir_key_press_hold_event_tracker
// Turns decoded IR frames into per-button press, long-press and hold flags.
// ---------------------------------------------------------------------------
// Requests enter on in_valid_i/in_ready_o: idle poll, received frame, flag
// query or key table write, selected by func_i. Every request yields exactly
// one result on out_valid_o/out_ready_i (event_seen_o, frame_matched_o).
// Hold and release times are set through cfg_we_i/cfg_index_i/cfg_wdata_i
// while no request is in flight.
// Throughput: a frame scans the 32-entry key table one entry per cycle
// through the table RAM read port, so it occupies the front until the
// first matching entry or the end of the table. The back end executes one
// job per cycle while its result register is empty or being read.
// Path: the front's job register feeds the queue, and the back end
// registers each result that it takes from the queue.
// Reset: key table all invalid, all button flags and timers cleared, hold
// time 500 ms, release timeout 100 ms.
// A stalled receiver holds the result register; up to two more jobs wait in
// the queue, and once it is full the front holds one more job in its push state.
// ---------------------------------------------------------------------------
module ir_key_press_hold_event_tracker import ikt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic [31:0]          now_ms_i,
  input  logic [7:0]           ir_address_i,
  input  logic [7:0]           ir_command_i,
  input  logic [BTN_W-1:0]     button_i,
  input  logic [1:0]           event_kind_i,
  input  logic [SLOT_W-1:0]    table_slot_i,
  input  logic [7:0]           entry_button_i,
  input  logic                 entry_long_ok_i,
  input  logic                 entry_hold_ok_i,
  input  logic [7:0]           entry_interval_i,
  input  logic                 entry_valid_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 event_seen_o,
  output logic                 frame_matched_o
);

  cfg_t cfg_q;
  logic push, full, pop, job_valid;
  job_t front_job, back_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_time_ms       <= HOLD_TIME_RST;
      cfg_q.release_timeout_ms <= RELEASE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_HOLD_TIME) begin
        cfg_q.hold_time_ms <= cfg_wdata_i;
      end else if (cfg_index_i == CFG_RELEASE_TIMEOUT) begin
        cfg_q.release_timeout_ms <= cfg_wdata_i;
      end
    end
  end

  ikt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .now_ms_i         (now_ms_i),
    .ir_address_i     (ir_address_i),
    .ir_command_i     (ir_command_i),
    .button_i         (button_i),
    .event_kind_i     (event_kind_i),
    .table_slot_i     (table_slot_i),
    .entry_button_i   (entry_button_i),
    .entry_long_ok_i  (entry_long_ok_i),
    .entry_hold_ok_i  (entry_hold_ok_i),
    .entry_interval_i (entry_interval_i),
    .entry_valid_i    (entry_valid_i),
    .full_i           (full),
    .push_o           (push),
    .job_o            (front_job)
  );

  ikt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (back_job)
  );

  ikt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .job_valid_i     (job_valid),
    .job_i           (back_job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .event_seen_o    (event_seen_o),
    .frame_matched_o (frame_matched_o)
  );

endmodule

@@ test/ikt_flag_checker.sv @@
// ---------------------------------------------------------------------------
// ikt_flag_checker
// Watches the tracker's ports, predicts every result in order and compares.
// ---------------------------------------------------------------------------
// Keeps its own copy of the key table, the per-button flags, the frame
// timers and the two registers. Each accepted request is run against that
// copy and its outcome queued; each accepted result is checked against the
// oldest queued outcome.
// ---------------------------------------------------------------------------
module ikt_flag_checker import ikt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [1:0]           func_i,
  input  logic [31:0]          now_ms_i,
  input  logic [7:0]           ir_address_i,
  input  logic [7:0]           ir_command_i,
  input  logic [BTN_W-1:0]     button_i,
  input  logic [1:0]           event_kind_i,
  input  logic [SLOT_W-1:0]    table_slot_i,
  input  logic [7:0]           entry_button_i,
  input  logic                 entry_long_ok_i,
  input  logic                 entry_hold_ok_i,
  input  logic [7:0]           entry_interval_i,
  input  logic                 entry_valid_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 event_seen_i,
  input  logic                 frame_matched_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   results_o,
  output int                   hits_o,
  output int                   seen_o
);

  typedef struct packed {
    logic seen;
    logic matched;
  } outcome_t;

  logic [FLAG_W-1:0] btn_flags [KEYS];
  key_entry_t        key_store [TABLE_ENTRIES];
  logic              key_live  [TABLE_ENTRIES];
  logic [15:0]       first_ms;
  logic [15:0]       last_hold_ms;
  logic [31:0]       last_frame_ms;
  logic [CFG_W-1:0]  hold_time;
  logic [CFG_W-1:0]  release_timeout;

  outcome_t request_outcomes [$];
  int       mismatches = 0;
  int       results    = 0;
  int       hits       = 0;
  int       flags_seen = 0;

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  function automatic void clear_button_state();
    foreach (btn_flags[i]) btn_flags[i] = '0;
    first_ms     = '0;
    last_hold_ms = '0;
  endfunction

  function automatic logic track_frame(input logic [7:0] addr, input logic [7:0] cmd,
                                       input logic [31:0] now);
    logic [15:0]       t16;
    logic [15:0]       since_first;
    logic [15:0]       since_hold;
    int                hit;
    key_entry_t        e;
    logic [FLAG_W-1:0] f;
    hit = -1;
    t16 = 16'(now & TIME_LO_MASK);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && key_live[i] && key_store[i].addr == addr && key_store[i].cmd == cmd) begin
        hit = i;
      end
    end
    if (hit < 0) return 1'b0;
    e = key_store[hit];
    // first match ends the search even when its button is unusable
    if (e.btn >= KEYS) return 1'b0;
    f = btn_flags[e.btn[BTN_W-1:0]];
    if (!f[FL_HELD]) begin
      f[FL_HELD]  = 1'b1;
      f[FL_PRESS] = 1'b1;
    end
    // zero stands for "not started", so a frame at t16 == 0 leaves it unset
    if (first_ms == '0) first_ms = t16;
    since_first = t16 - first_ms;
    if (since_first >= hold_time) begin
      if (e.long_ok && !f[FL_LONG_TRG]) begin
        f[FL_LONG]     = 1'b1;
        f[FL_LONG_TRG] = 1'b1;
      end
      if (e.hold_ok) begin
        since_hold = t16 - last_hold_ms;
        if (last_hold_ms == '0 || since_hold >= {8'h00, e.interval}) begin
          last_hold_ms = t16;
          f[FL_HOLD]   = 1'b1;
        end else begin
          f[FL_HOLD] = 1'b0;
        end
      end
    end
    btn_flags[e.btn[BTN_W-1:0]] = f;
    return 1'b1;
  endfunction

  function automatic logic take_flag(input logic [BTN_W-1:0] btn, input logic [1:0] kind);
    int   pos;
    logic was;
    case (kind)
      KIND_PRESS: pos = FL_PRESS;
      KIND_LONG:  pos = FL_LONG;
      KIND_HOLD:  pos = FL_HOLD;
      default:    return 1'b0;
    endcase
    was = btn_flags[btn][pos];
    btn_flags[btn][pos] = 1'b0;
    return was;
  endfunction

  function automatic outcome_t predict_request();
    outcome_t    o;
    logic [31:0] quiet;
    o = '0;
    case (func_i)
      FUNC_POLL: begin
        quiet = now_ms_i - last_frame_ms;
        if (quiet >= {16'h0000, release_timeout}) clear_button_state();
      end
      FUNC_FRAME: begin
        last_frame_ms = now_ms_i;
        o.matched = track_frame(ir_address_i, ir_command_i, now_ms_i);
      end
      FUNC_QUERY: begin
        o.seen = take_flag(button_i, event_kind_i);
      end
      FUNC_WRITE: begin
        key_store[table_slot_i] = '{addr: ir_address_i, cmd: ir_command_i,
                                    btn: entry_button_i, interval: entry_interval_i,
                                    long_ok: entry_long_ok_i, hold_ok: entry_hold_ok_i};
        key_live[table_slot_i] = entry_valid_i;
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t got;
    outcome_t want;
    if (!rst_ni) begin
      clear_button_state();
      foreach (key_live[i]) begin
        key_live[i]  = 1'b0;
        key_store[i] = '0;
      end
      last_frame_ms   = '0;
      hold_time       = HOLD_TIME_RST;
      release_timeout = RELEASE_TIMEOUT_RST;
      request_outcomes.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_HOLD_TIME) begin
          hold_time = cfg_wdata_i;
        end else if (cfg_index_i == CFG_RELEASE_TIMEOUT) begin
          release_timeout = cfg_wdata_i;
        end
      end
      // results leave before the request of this edge is queued
      if (out_valid_i && out_ready_i) begin
        got.seen    = event_seen_i;
        got.matched = frame_matched_i;
        results++;
        if (request_outcomes.size() == 0) begin
          note_mismatch($sformatf("result seen=%0b matched=%0b with no request outstanding",
                                  got.seen, got.matched));
        end else begin
          want = request_outcomes.pop_front();
          if (want.matched) hits++;
          if (want.seen) flags_seen++;
          if (got.seen !== want.seen) begin
            note_mismatch($sformatf("result %0d event_seen expected %0b got %0b",
                                    results, want.seen, got.seen));
          end
          if (got.matched !== want.matched) begin
            note_mismatch($sformatf("result %0d frame_matched expected %0b got %0b",
                                    results, want.matched, got.matched));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        request_outcomes.push_back(predict_request());
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= request_outcomes.size();
    results_o    <= results;
    hits_o       <= hits;
    seen_o       <= flags_seen;
  end

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the IR key press / hold event tracker.
// ---------------------------------------------------------------------------
// A directed opening under reset register values covers table shadowing,
// unusable buttons, invalid entries, the zero first-frame time, 16-bit time
// wrap and the release clear. Then several register settings follow, each
// with key-press bursts (frames of one key at random spacing, queries and
// polls in between), table writes, queries and random noise. Both channels
// idle at random; the checker beside the block does all comparison.
// ---------------------------------------------------------------------------
module tb;
  import ikt_pkg::*;

  localparam int         HALF_PERIOD   = 4;
  localparam int         RESET_CYCLES  = 12;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         LIMIT_CYCLES  = 1_000_000;
  localparam int         PHASES        = 6;
  localparam int         PHASE_ITEMS   = 165;
  localparam logic [1:0] KIND_NONE     = 2'd3;

  typedef struct {
    func_e             func;
    logic [31:0]       now;
    logic [7:0]        addr;
    logic [7:0]        cmd;
    logic [BTN_W-1:0]  btn;
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        entry_btn;
    logic              long_ok;
    logic              hold_ok;
    logic [7:0]        interval;
    logic              valid;
  } ir_request_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [1:0]           func_i;
  logic [31:0]          now_ms_i;
  logic [7:0]           ir_address_i;
  logic [7:0]           ir_command_i;
  logic [BTN_W-1:0]     button_i;
  logic [1:0]           event_kind_i;
  logic [SLOT_W-1:0]    table_slot_i;
  logic [7:0]           entry_button_i;
  logic                 entry_long_ok_i;
  logic                 entry_hold_ok_i;
  logic [7:0]           entry_interval_i;
  logic                 entry_valid_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 event_seen_o;
  logic                 frame_matched_o;

  int mismatch_count;
  int pending_count;
  int result_count;
  int hit_count;
  int seen_count;

  // keys written so far, used to aim frames at live entries
  logic [7:0] slot_addr [TABLE_ENTRIES];
  logic [7:0] slot_cmd  [TABLE_ENTRIES];
  logic [7:0] slot_btn  [TABLE_ENTRIES];
  bit         slot_live [TABLE_ENTRIES];

  logic [31:0]      clock_ms;
  logic [CFG_W-1:0] cur_release;
  int               sent;
  bit               no_idle;

  always #HALF_PERIOD clk_i = ~clk_i;

  ir_key_press_hold_event_tracker dut (.*);

  ikt_flag_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .func_i           (func_i),
    .now_ms_i         (now_ms_i),
    .ir_address_i     (ir_address_i),
    .ir_command_i     (ir_command_i),
    .button_i         (button_i),
    .event_kind_i     (event_kind_i),
    .table_slot_i     (table_slot_i),
    .entry_button_i   (entry_button_i),
    .entry_long_ok_i  (entry_long_ok_i),
    .entry_hold_ok_i  (entry_hold_ok_i),
    .entry_interval_i (entry_interval_i),
    .entry_valid_i    (entry_valid_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_seen_i     (event_seen_o),
    .frame_matched_i  (frame_matched_o),
    .mismatches_o     (mismatch_count),
    .pending_o        (pending_count),
    .results_o        (result_count),
    .hits_o           (hit_count),
    .seen_o           (seen_count)
  );

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [1:0] pick_kind();
    return ($urandom_range(0, 19) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
  endfunction

  function automatic ir_request_t any_req();
    ir_request_t r;
    r.func      = func_e'($urandom_range(0, 3));
    r.now       = $urandom();
    r.addr      = 8'($urandom_range(0, 255));
    r.cmd       = 8'($urandom_range(0, 255));
    r.btn       = BTN_W'($urandom_range(0, KEYS - 1));
    r.kind      = 2'($urandom_range(0, 3));
    r.slot      = SLOT_W'($urandom_range(0, TABLE_ENTRIES - 1));
    r.entry_btn = 8'($urandom_range(0, 255));
    r.long_ok   = 1'($urandom_range(0, 1));
    r.hold_ok   = 1'($urandom_range(0, 1));
    r.interval  = 8'($urandom_range(0, 255));
    r.valid     = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic ir_request_t frame_req(input logic [7:0] addr, input logic [7:0] cmd,
                                            input logic [31:0] now);
    ir_request_t r;
    r      = any_req();
    r.func = FUNC_FRAME;
    r.addr = addr;
    r.cmd  = cmd;
    r.now  = now;
    return r;
  endfunction

  function automatic ir_request_t poll_req(input logic [31:0] now);
    ir_request_t r;
    r      = any_req();
    r.func = FUNC_POLL;
    r.now  = now;
    return r;
  endfunction

  function automatic ir_request_t query_req(input logic [BTN_W-1:0] btn,
                                            input logic [1:0] kind);
    ir_request_t r;
    r      = any_req();
    r.func = FUNC_QUERY;
    r.btn  = btn;
    r.kind = kind;
    return r;
  endfunction

  function automatic ir_request_t write_req(input logic [SLOT_W-1:0] slot,
                                            input logic [7:0] addr, input logic [7:0] cmd,
                                            input logic [7:0] btn, input logic long_ok,
                                            input logic hold_ok, input logic [7:0] interval,
                                            input logic valid);
    ir_request_t r;
    r           = any_req();
    r.func      = FUNC_WRITE;
    r.slot      = slot;
    r.addr      = addr;
    r.cmd       = cmd;
    r.entry_btn = btn;
    r.long_ok   = long_ok;
    r.hold_ok   = hold_ok;
    r.interval  = interval;
    r.valid     = valid;
    return r;
  endfunction

  // valid stays high from one request to the next unless a gap is drawn
  task automatic send_req(input ir_request_t r);
    int gap;
    gap = (!no_idle && $urandom_range(0, 99) < 30) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    func_i           <= r.func;
    now_ms_i         <= r.now;
    ir_address_i     <= r.addr;
    ir_command_i     <= r.cmd;
    button_i         <= r.btn;
    event_kind_i     <= r.kind;
    table_slot_i     <= r.slot;
    entry_button_i   <= r.entry_btn;
    entry_long_ok_i  <= r.long_ok;
    entry_hold_ok_i  <= r.hold_ok;
    entry_interval_i <= r.interval;
    entry_valid_i    <= r.valid;
    if (r.func == FUNC_WRITE) begin
      slot_addr[r.slot] = r.addr;
      slot_cmd[r.slot]  = r.cmd;
      slot_btn[r.slot]  = r.entry_btn;
      slot_live[r.slot] = r.valid && (r.entry_btn < KEYS);
    end
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] rel,
                            input logic [CFG_IDX_W-1:0] junk_idx);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HOLD_TIME;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_index_i <= CFG_RELEASE_TIMEOUT;
    cfg_wdata_i <= rel;
    @(posedge clk_i);
    // an index past the register file must change nothing
    cfg_index_i <= junk_idx;
    cfg_wdata_i <= CFG_W'($urandom_range(0, 65535));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_key_burst();
    int s;
    int n;
    int step_hi;
    s = $urandom_range(0, TABLE_ENTRIES - 1);
    for (int t = 0; t < 8 && !slot_live[s]; t++) s = $urandom_range(0, TABLE_ENTRIES - 1);
    n       = $urandom_range(2, 16);
    step_hi = $urandom_range(5, 150);
    if ($urandom_range(0, 99) < 6) begin
      clock_ms = {clock_ms[31:16] + 16'd1, 16'h0000};
      send_req(frame_req(slot_addr[s], slot_cmd[s], clock_ms));
    end
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(0, step_hi);
      send_req(frame_req(slot_addr[s], slot_cmd[s], clock_ms));
      if ($urandom_range(0, 99) < 30) send_req(query_req(slot_btn[s][BTN_W-1:0], pick_kind()));
      if ($urandom_range(0, 99) < 10) begin
        send_req(poll_req(clock_ms + $urandom_range(0, cur_release)));
      end
    end
    if ($urandom_range(0, 99) < 60) begin
      clock_ms += cur_release + $urandom_range(0, 50);
      send_req(poll_req(clock_ms));
    end
    if ($urandom_range(0, 99) < 50) begin
      for (int k = 0; k < 3; k++) send_req(query_req(slot_btn[s][BTN_W-1:0], 2'(k)));
    end
  endtask

  task automatic random_entry();
    logic [7:0] btn;
    logic [7:0] interval;
    btn      = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, KEYS - 1))
                                            : 8'($urandom_range(0, 255));
    interval = ($urandom_range(0, 99) < 70) ? 8'($urandom_range(0, 60))
                                            : 8'($urandom_range(0, 255));
    send_req(write_req(SLOT_W'($urandom_range(0, TABLE_ENTRIES - 1)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), btn,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       interval, $urandom_range(0, 99) < 90));
  endtask

  initial begin
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!no_idle && $urandom_range(0, 99) < 25) begin
        out_ready_i <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int               goal;
    int               roll;
    logic [CFG_W-1:0] hold_pick [PHASES];
    logic [CFG_W-1:0] rel_pick  [PHASES];
    hold_pick = '{16'd0, 16'hFFFF, 16'd150, 16'd300, 16'd40, 16'd0};
    rel_pick  = '{16'd0, 16'hFFFF, 16'd120, 16'd60, 16'd1000, 16'd0};
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= '0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    func_i           <= FUNC_POLL;
    now_ms_i         <= '0;
    ir_address_i     <= '0;
    ir_command_i     <= '0;
    button_i         <= '0;
    event_kind_i     <= KIND_PRESS;
    table_slot_i     <= '0;
    entry_button_i   <= '0;
    entry_long_ok_i  <= 1'b0;
    entry_hold_ok_i  <= 1'b0;
    entry_interval_i <= '0;
    entry_valid_i    <= 1'b0;
    clock_ms    = 32'd5000;
    cur_release = RELEASE_TIMEOUT_RST;
    no_idle     = 1'b0;
    sent        = 0;
    // slots never written aim at key 00/00
    foreach (slot_live[i]) begin
      slot_addr[i] = '0;
      slot_cmd[i]  = '0;
      slot_btn[i]  = '0;
      slot_live[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // table layout: a shadowed duplicate, an unusable button that hides a
    // later match, and an invalid entry
    send_req(write_req(5'd0, 8'h12, 8'h34, 8'd3, 1'b1, 1'b1, 8'd0, 1'b1));
    send_req(write_req(5'd31, 8'hFF, 8'hFF, 8'd31, 1'b1, 1'b1, 8'd255, 1'b1));
    send_req(write_req(5'd1, 8'h12, 8'h34, 8'd7, 1'b0, 1'b0, 8'd10, 1'b1));
    send_req(write_req(5'd2, 8'h00, 8'h00, 8'd200, 1'b1, 1'b1, 8'd5, 1'b1));
    send_req(write_req(5'd3, 8'h00, 8'h00, 8'd5, 1'b1, 1'b1, 8'd5, 1'b1));
    send_req(write_req(5'd4, 8'h55, 8'hAA, 8'd9, 1'b1, 1'b1, 8'd5, 1'b0));
    send_req(frame_req(8'h55, 8'hAA, 32'd1000));
    send_req(frame_req(8'h00, 8'h00, 32'd1010));
    // low time bits zero: start time stays unset
    send_req(frame_req(8'h12, 8'h34, 32'h0001_0000));
    send_req(query_req(5'd3, KIND_PRESS));
    send_req(query_req(5'd3, KIND_PRESS));
    send_req(frame_req(8'h12, 8'h34, 32'h0001_0100));
    send_req(frame_req(8'h12, 8'h34, 32'h0001_0100 + 32'd500));
    send_req(query_req(5'd3, KIND_LONG));
    send_req(query_req(5'd3, KIND_HOLD));
    send_req(query_req(5'd3, KIND_NONE));
    send_req(query_req(5'd7, KIND_PRESS));
    send_req(frame_req(8'h12, 8'h34, 32'h0001_0100 + 32'd500));
    send_req(poll_req(32'h0001_0100 + 32'd550));
    send_req(query_req(5'd3, KIND_HOLD));
    send_req(poll_req(32'h0001_0100 + 32'd650));
    send_req(query_req(5'd3, KIND_PRESS));
    send_req(frame_req(8'hFF, 8'hFF, 32'hFFFF_FFF0));
    send_req(frame_req(8'hFF, 8'hFF, 32'h0000_0010));
    send_req(query_req(5'd31, KIND_PRESS));
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        hold_pick[p] = CFG_W'($urandom_range(0, 65535));
        rel_pick[p]  = CFG_W'($urandom_range(0, 65535));
      end
      write_regs(hold_pick[p], rel_pick[p], (p == 0) ? 8'hFF : 8'($urandom_range(2, 255)));
      cur_release = rel_pick[p];
      goal = sent + PHASE_ITEMS;
      while (sent < goal) begin
        if ($urandom_range(0, 9) == 0) no_idle = !no_idle;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          run_key_burst();
        end else if (roll < 70) begin
          random_entry();
        end else if (roll < 85) begin
          send_req(query_req(BTN_W'($urandom_range(0, KEYS - 1)), pick_kind()));
        end else if (roll < 95) begin
          send_req(any_req());
        end else begin
          clock_ms = $urandom();
          send_req(poll_req(clock_ms));
        end
      end
      // hold off until every result is back before touching the registers
      wait_quiet();
    end

    $display("Ran %0d requests across %0d register settings; %0d frames hit a key.",
             sent, PHASES + 1, hit_count);
    $display("%0d queries found their flag set; %0d results compared.",
             seen_count, result_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
